### rtl/swrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants of the sliding window region mapper.
// ----------------------------------------------------------------------------
package swrm_pkg;

   localparam logic [1:0] REG_MIN_WIDTH    = 2'd0;
   localparam logic [1:0] REG_MIN_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_SLIDE_STRIDE = 2'd2;
   localparam logic [1:0] REG_TASKS_PER_PE = 2'd3;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SZ_INIT, ST_SZ_STEP, ST_SZ_CLAMP, ST_CENTRE, ST_SL_INIT,
      ST_SL_RESET, ST_SL_LOAD, ST_ADV, ST_CHECK, ST_SUM, ST_SUM_TAIL,
      ST_JUDGE, ST_GROW, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_A, PH_B, PH_C
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_SIZE_INIT, OP_SIZE_STEP, OP_CLAMP, OP_CENTRE,
      OP_LAST_INIT, OP_LAST_GRID, OP_LOAD, OP_ADVANCE, OP_SUM_STEP,
      OP_SET_LAST, OP_GROW, OP_FAIL, OP_FAIL_SLIDE, OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   found;
   } cmd_type;

   typedef struct packed {
      logic size_more;
      logic can_grow;
      logic fit;
      logic sum_last;
      logic cond_a;
      logic cond_b;
   } sts_type;

endpackage

### rtl/swrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swrm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/swrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ctrl
// Controller sequencing window sizing, placement, page sums and growth.
// ----------------------------------------------------------------------------
module swrm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic             req_has_static,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output swrm_pkg::cmd_type cmd,
   input  swrm_pkg::sts_type sts
);

   swrm_pkg::state_type state_ff, state_in;
   swrm_pkg::phase_type phase_ff, phase_in;
   logic static_ff, static_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         swrm_pkg::ST_IDLE: begin
            if (req_valid && req_kind == swrm_pkg::KIND_REQUEST) begin
               state_in = swrm_pkg::ST_SZ_INIT;
            end
         end
         swrm_pkg::ST_SZ_INIT:  state_in = swrm_pkg::ST_SZ_STEP;
         swrm_pkg::ST_SZ_STEP: begin
            if (!sts.size_more) begin
               state_in = swrm_pkg::ST_SZ_CLAMP;
            end
         end
         swrm_pkg::ST_SZ_CLAMP: begin
            state_in = static_ff ? swrm_pkg::ST_CENTRE : swrm_pkg::ST_SL_INIT;
         end
         swrm_pkg::ST_CENTRE:   state_in = swrm_pkg::ST_SUM;
         swrm_pkg::ST_SL_INIT:  state_in = swrm_pkg::ST_SL_LOAD;
         swrm_pkg::ST_SL_RESET: state_in = swrm_pkg::ST_SL_LOAD;
         swrm_pkg::ST_SL_LOAD: begin
            state_in = swrm_pkg::ST_ADV;
            phase_in = swrm_pkg::PH_A;
         end
         swrm_pkg::ST_ADV:      state_in = swrm_pkg::ST_CHECK;
         swrm_pkg::ST_CHECK: begin
            unique case (phase_ff)
               swrm_pkg::PH_A: begin
                  if (sts.cond_a) begin
                     state_in = swrm_pkg::ST_SUM;
                  end else begin
                     phase_in = swrm_pkg::PH_B;
                  end
               end
               swrm_pkg::PH_B: begin
                  state_in = swrm_pkg::ST_SUM;
                  if (!sts.cond_b) begin
                     phase_in = swrm_pkg::PH_C;
                  end
               end
               default: state_in = swrm_pkg::ST_SUM;
            endcase
         end
         swrm_pkg::ST_SUM: begin
            if (sts.sum_last) begin
               state_in = swrm_pkg::ST_SUM_TAIL;
            end
         end
         swrm_pkg::ST_SUM_TAIL: state_in = swrm_pkg::ST_JUDGE;
         swrm_pkg::ST_JUDGE: begin
            if (sts.fit) begin
               state_in = swrm_pkg::ST_DONE;
            end else if (static_ff || phase_ff == swrm_pkg::PH_C) begin
               state_in = swrm_pkg::ST_GROW;
            end else begin
               state_in = swrm_pkg::ST_ADV;
            end
         end
         swrm_pkg::ST_GROW: begin
            if (!sts.can_grow) begin
               state_in = swrm_pkg::ST_DONE;
            end else if (static_ff) begin
               state_in = swrm_pkg::ST_SUM;
            end else begin
               state_in = swrm_pkg::ST_SL_RESET;
            end
         end
         swrm_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = swrm_pkg::ST_IDLE;
            end
         end
         default: state_in = swrm_pkg::ST_IDLE;
      endcase
   end

   assign out_load = (state_ff == swrm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // outputs
   always_comb begin
      cmd.op    = swrm_pkg::OP_NONE;
      cmd.found = found_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         swrm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = swrm_pkg::OP_ACCEPT;
            end
         end
         swrm_pkg::ST_SZ_INIT:  cmd.op = swrm_pkg::OP_SIZE_INIT;
         swrm_pkg::ST_SZ_STEP: begin
            if (sts.size_more) begin
               cmd.op = swrm_pkg::OP_SIZE_STEP;
            end
         end
         swrm_pkg::ST_SZ_CLAMP: cmd.op = swrm_pkg::OP_CLAMP;
         swrm_pkg::ST_CENTRE:   cmd.op = swrm_pkg::OP_CENTRE;
         swrm_pkg::ST_SL_INIT:  cmd.op = swrm_pkg::OP_LAST_INIT;
         swrm_pkg::ST_SL_RESET: cmd.op = swrm_pkg::OP_LAST_GRID;
         swrm_pkg::ST_SL_LOAD:  cmd.op = swrm_pkg::OP_LOAD;
         swrm_pkg::ST_ADV:      cmd.op = swrm_pkg::OP_ADVANCE;
         swrm_pkg::ST_SUM:      cmd.op = swrm_pkg::OP_SUM_STEP;
         swrm_pkg::ST_JUDGE: begin
            if (sts.fit && !static_ff) begin
               cmd.op = swrm_pkg::OP_SET_LAST;
            end
         end
         swrm_pkg::ST_GROW: begin
            if (sts.can_grow) begin
               cmd.op = swrm_pkg::OP_GROW;
            end else begin
               cmd.op = static_ff ? swrm_pkg::OP_FAIL : swrm_pkg::OP_FAIL_SLIDE;
            end
         end
         swrm_pkg::ST_DONE: begin
            if (out_load) begin
               cmd.op = swrm_pkg::OP_OUTPUT;
            end
         end
         default: cmd.op = swrm_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      static_in = static_ff;
      if (state_ff == swrm_pkg::ST_IDLE && req_valid) begin
         static_in = req_has_static;
      end
      found_in = found_ff;
      if (state_ff == swrm_pkg::ST_JUDGE) begin
         found_in = sts.fit;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swrm_pkg::ST_IDLE;
         phase_ff     <= swrm_pkg::PH_A;
         static_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         static_ff    <= static_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_request_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == swrm_pkg::KIND_REQUEST)
      |=> state_ff == swrm_pkg::ST_SZ_INIT)
      else $error("mapping request did not start sizing");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swrm_pkg::ST_DONE && rsp_valid_ff && !rsp_ready)
      |=> state_ff == swrm_pkg::ST_DONE && rsp_valid_ff)
      else $error("result overwritten before it was taken");

   a_tail_after_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == swrm_pkg::ST_SUM_TAIL |-> $past(state_ff) == swrm_pkg::ST_SUM)
      else $error("sum tail without sum pass");

   a_judge_after_tail: assert property (@(posedge clock) disable iff (reset)
      state_ff == swrm_pkg::ST_JUDGE |-> $past(state_ff) == swrm_pkg::ST_SUM_TAIL)
      else $error("window judged before its sum completed");

endmodule

### rtl/swrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_dp
// Datapath: config registers, page store, window geometry and page sum.
// ----------------------------------------------------------------------------
module swrm_dp #(
   parameter int GRID_X = 8,
   parameter int GRID_N = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  swrm_pkg::cmd_type cmd,
   output swrm_pkg::sts_type sts,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data,
   input  logic              req_kind,
   input  logic [5:0]        req_pe_index,
   input  logic [3:0]        req_free_pages,
   input  logic [7:0]        req_task_count,
   input  logic [2:0]        req_center_x,
   input  logic [2:0]        req_center_y,
   output logic              rsp_found,
   output logic [2:0]        rsp_win_x,
   output logic [2:0]        rsp_win_y,
   output logic [3:0]        rsp_win_width,
   output logic [3:0]        rsp_win_height
);

   localparam int ROWS = (GRID_N / GRID_X > 0) ? GRID_N / GRID_X : 1;
   localparam int GMAX = GRID_X > ROWS ? GRID_X : ROWS;
   localparam int DW   = $clog2(GMAX + 1) + 5;
   localparam int AR   = 2 * DW;
   localparam int PW   = AR + 4;
   localparam int AW   = GRID_N > 1 ? $clog2(GRID_N) : 1;
   localparam int IW   = $clog2(GRID_N + GRID_X) + 1;
   localparam int SW   = $clog2(GRID_N * 15 + 1);
   localparam int CW   = (SW > 8 ? SW : 8) + 1;
   localparam logic [DW-1:0] GXD = DW'(GRID_X);
   localparam logic [DW-1:0] RD  = DW'(ROWS);
   localparam logic [DW-1:0] LC_RST = GRID_X >= 2 ? DW'(GRID_X - 2) : '0;
   localparam logic [DW-1:0] LR_RST = ROWS >= 2 ? DW'(ROWS - 2) : '0;

   logic [3:0] min_w_ff, min_h_ff, stride_ff, tpe_ff;
   logic [7:0] need_ff;
   logic [2:0] cx_ff, cy_ff;
   logic [DW-1:0] w_ff, w_in, h_ff, h_in, x_ff, x_in, y_ff, y_in;
   logic [DW-1:0] lc_ff, lc_in, lr_ff, lr_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [AR-1:0] area_ff, area_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic pend_ff, pend_in, vrd_ff;
   logic [GRID_N-1:0] valid_ff;
   logic rsp_found_ff;
   logic [2:0] rsp_x_ff, rsp_y_ff;
   logic [3:0] rsp_w_ff, rsp_h_ff;

   logic [DW-1:0] minw1, minh1, step, gw, gh, hw, hh, x0, y0, cxe, cye;
   logic [DW-1:0] ax, ay, adv_x, adv_y;
   logic [PW-1:0] prod;
   logic [IW-1:0] idx;
   logic in_range, first, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [3:0] rd_data;

   assign minw1 = min_w_ff != 4'd0 ? DW'(min_w_ff) : DW'(1);
   assign minh1 = min_h_ff != 4'd0 ? DW'(min_h_ff) : DW'(1);
   assign step  = stride_ff != 4'd0 ? DW'(stride_ff) : DW'(1);
   assign prod  = PW'(area_ff) * PW'(tpe_ff);

   assign sts.size_more = (prod < PW'(need_ff)) && !(w_ff >= GXD && h_ff >= RD);
   assign sts.can_grow  = (w_ff < GXD) || (h_ff < RD);
   assign sts.fit       = CW'(acc_ff) >= CW'(need_ff);
   assign sts.sum_last  = (ox_ff == w_ff - DW'(1)) && (oy_ff == h_ff - DW'(1));
   assign sts.cond_a    = (x_ff > lc_ff) || (y_ff > lr_ff);
   assign sts.cond_b    = (x_ff < lc_ff) || (y_ff < lr_ff);

   // grown size
   always_comb begin
      gw = w_ff;
      gh = h_ff;
      if (h_ff <= w_ff && h_ff < RD) begin
         gh = h_ff + DW'(1);
      end else if (w_ff < GXD) begin
         gw = w_ff + DW'(1);
      end else if (h_ff < RD) begin
         gh = h_ff + DW'(1);
      end
   end

   // centred start position
   always_comb begin
      hw  = w_ff >> 1;
      hh  = h_ff >> 1;
      cxe = DW'(cx_ff);
      cye = DW'(cy_ff);
      x0  = cxe >= hw ? cxe - hw : '0;
      y0  = cye >= hh ? cye - hh : '0;
      if (x0 + w_ff > GXD) begin
         x0 = GXD - w_ff;
      end
      if (y0 + h_ff > RD) begin
         y0 = RD - h_ff;
      end
   end

   // slide step with wrap
   always_comb begin
      adv_x = '0;
      adv_y = '0;
      if (x_ff + w_ff < GXD) begin
         adv_y = y_ff;
         adv_x = x_ff + step;
         if (adv_x + w_ff > GXD) begin
            adv_x = GXD - w_ff;
         end
      end else if (y_ff + h_ff < RD) begin
         adv_y = y_ff + step;
         if (adv_y + h_ff > RD) begin
            adv_y = RD - h_ff;
         end
      end
   end

   // cell address of the sum pass
   assign ax       = x_ff + ox_ff;
   assign ay       = y_ff + oy_ff;
   assign idx      = IW'(ay) * IW'(GRID_X) + IW'(ax);
   assign in_range = idx < IW'(GRID_N);
   assign rd_addr  = idx[AW-1:0];
   assign first    = (ox_ff == '0) && (oy_ff == '0);

   assign wr_en   = (cmd.op == swrm_pkg::OP_ACCEPT) && (req_kind == swrm_pkg::KIND_WRITE)
                    && (32'(req_pe_index) < GRID_N);
   assign wr_addr = AW'(req_pe_index);

   swrm_ram #(
      .WIDTH (4),
      .DEPTH (GRID_N)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_free_pages),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      lc_in   = lc_ff;
      lr_in   = lr_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      area_in = area_ff;
      pend_in = 1'b0;
      acc_in  = ((cmd.op == swrm_pkg::OP_SUM_STEP && first) ? '0 : acc_ff)
                + ((pend_ff && vrd_ff) ? SW'(rd_data) : '0);
      case (cmd.op)
         swrm_pkg::OP_SIZE_INIT: begin
            w_in    = minw1;
            h_in    = minh1;
            area_in = AR'(minw1) * AR'(minh1);
         end
         swrm_pkg::OP_SIZE_STEP: begin
            if (h_ff <= w_ff) begin
               h_in    = h_ff + DW'(1);
               area_in = area_ff + AR'(w_ff);
            end else begin
               w_in    = w_ff + DW'(1);
               area_in = area_ff + AR'(h_ff);
            end
         end
         swrm_pkg::OP_CLAMP: begin
            w_in = w_ff > GXD ? GXD : w_ff;
            h_in = h_ff > RD ? RD : h_ff;
            x_in = '0;
            y_in = '0;
         end
         swrm_pkg::OP_CENTRE: begin
            x_in = x0;
            y_in = y0;
         end
         swrm_pkg::OP_LAST_INIT: begin
            if (w_ff != minw1 || h_ff != minh1) begin
               lc_in = GXD - w_ff;
               lr_in = RD - h_ff;
            end else begin
               lc_in = lc_ff > GXD - w_ff ? GXD - w_ff : lc_ff;
               lr_in = lr_ff > RD - h_ff ? RD - h_ff : lr_ff;
            end
         end
         swrm_pkg::OP_LAST_GRID: begin
            lc_in = GXD - w_ff;
            lr_in = RD - h_ff;
         end
         swrm_pkg::OP_LOAD: begin
            x_in = lc_ff;
            y_in = lr_ff;
         end
         swrm_pkg::OP_ADVANCE: begin
            x_in = adv_x;
            y_in = adv_y;
         end
         swrm_pkg::OP_SUM_STEP: begin
            pend_in = in_range;
            if (ox_ff == w_ff - DW'(1)) begin
               ox_in = '0;
               oy_in = (oy_ff == h_ff - DW'(1)) ? '0 : oy_ff + DW'(1);
            end else begin
               ox_in = ox_ff + DW'(1);
            end
         end
         swrm_pkg::OP_SET_LAST: begin
            lc_in = x_ff;
            lr_in = y_ff;
         end
         swrm_pkg::OP_GROW: begin
            w_in = gw;
            h_in = gh;
            if (x_ff + gw > GXD) begin
               x_in = GXD - gw;
            end
            if (y_ff + gh > RD) begin
               y_in = RD - gh;
            end
         end
         swrm_pkg::OP_FAIL: begin
            x_in = '0;
            y_in = '0;
         end
         swrm_pkg::OP_FAIL_SLIDE: begin
            x_in  = '0;
            y_in  = '0;
            lc_in = '0;
            lr_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_w_ff  <= 4'd2;
         min_h_ff  <= 4'd2;
         stride_ff <= 4'd2;
         tpe_ff    <= 4'd4;
         lc_ff     <= LC_RST;
         lr_ff     <= LR_RST;
         ox_ff     <= '0;
         oy_ff     <= '0;
         pend_ff   <= 1'b0;
         valid_ff  <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               swrm_pkg::REG_MIN_WIDTH:    min_w_ff  <= csr_data;
               swrm_pkg::REG_MIN_HEIGHT:   min_h_ff  <= csr_data;
               swrm_pkg::REG_SLIDE_STRIDE: stride_ff <= csr_data;
               swrm_pkg::REG_TASKS_PER_PE: tpe_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         lc_ff   <= lc_in;
         lr_ff   <= lr_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         pend_ff <= pend_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == swrm_pkg::OP_ACCEPT) begin
         need_ff <= req_task_count;
         cx_ff   <= req_center_x;
         cy_ff   <= req_center_y;
      end
      w_ff    <= w_in;
      h_ff    <= h_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      area_ff <= area_in;
      acc_ff  <= acc_in;
      vrd_ff  <= valid_ff[rd_addr];
      if (cmd.op == swrm_pkg::OP_OUTPUT) begin
         rsp_found_ff <= cmd.found;
         rsp_x_ff     <= x_ff[2:0];
         rsp_y_ff     <= y_ff[2:0];
         rsp_w_ff     <= w_ff[3:0];
         rsp_h_ff     <= h_ff[3:0];
      end
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_win_x      = rsp_x_ff;
   assign rsp_win_y      = rsp_y_ff;
   assign rsp_win_width  = rsp_w_ff;
   assign rsp_win_height = rsp_h_ff;

endmodule

### rtl/sliding_window_region_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_region_mapper
// Page count store and window search over a processor grid.
// ----------------------------------------------------------------------------
// page count writes give no response
// a mapping request first sizes the window up from the minimum size, then sums
// the pages of each candidate window; static: placed around the centre and grown
// on a miss; sliding: starts from the last position and slides step by step,
// regrowing after a full pass; the response is registered; one request in flight at a time
// reset restores register defaults and last position, clears page valid bits
module sliding_window_region_mapper #(
   parameter int GRID_X = 8,
   parameter int GRID_N = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [5:0] req_pe_index,
   input  logic [3:0] req_free_pages,
   input  logic [7:0] req_task_count,
   input  logic       req_has_static,
   input  logic [2:0] req_center_x,
   input  logic [2:0] req_center_y,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [2:0] rsp_win_x,
   output logic [2:0] rsp_win_y,
   output logic [3:0] rsp_win_width,
   output logic [3:0] rsp_win_height
);

   swrm_pkg::cmd_type cmd;
   swrm_pkg::sts_type sts;

   swrm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_has_static (req_has_static),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .sts            (sts)
   );

   swrm_dp #(
      .GRID_X (GRID_X),
      .GRID_N (GRID_N)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_kind       (req_kind),
      .req_pe_index   (req_pe_index),
      .req_free_pages (req_free_pages),
      .req_task_count (req_task_count),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .rsp_found      (rsp_found),
      .rsp_win_x      (rsp_win_x),
      .rsp_win_y      (rsp_win_y),
      .rsp_win_width  (rsp_win_width),
      .rsp_win_height (rsp_win_height)
   );

endmodule
